// File: design/page_bitmap_allocator_defines.svh
// assertion macros shared by the checker
`ifndef PAGE_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_BITMAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define PBA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page allocator check failed");

// next-cycle implication
`define PBA_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page allocator check failed");

`endif

// File: design/pba_pkg.sv
package pba_pkg;

   localparam int PAGE_W  = 16;
   localparam int COUNT_W = 17;

   localparam logic [COUNT_W-1:0] FREE_MAX      = 17'h1FFFF;
   localparam logic [COUNT_W-1:0] PAGES_RESET   = 17'd65536;
   localparam logic [COUNT_W-1:0] FLOOR_RESET   = 17'd1536;

   typedef enum logic [1:0] {
      CMD_ADD  = 2'd0,
      CMD_ONE  = 2'd1,
      CMD_RUN  = 2'd2,
      CMD_FREE = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_PAGES = 1'b0,
      REG_FLOOR = 1'b1
   } reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_PROC,
      ST_FIN
   } state_type;

endpackage

// File: design/pba_ram.sv
module pba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: design/page_bitmap_allocator.sv
// channel | ports                                   | direction
// req     | req_valid req_stall req_cmd ...         | in, accepted when valid & !stall
// rsp     | rsp_valid rsp_stall rsp_status ...      | out, taken when valid & !stall
// csr     | csr_write_enable csr_index csr_write_data | in, written on enable
// An item walks the usage map one word (MAP_WORD_BITS pages) per cycle through
// the map RAM (one read and one write port); alloc-one may make two passes,
// alloc-run a scan pass plus a marking pass over the run's words.
// After reset a clearing pass over the MAX_PAGES/MAP_WORD_BITS map words sets every page
// used; no item is accepted meanwhile. One item at a time; a finished result
// waits in the output register while the next item is taken.
module page_bitmap_allocator #(
   parameter int MAX_PAGES     = 65536,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [pba_pkg::PAGE_W-1:0]    req_base_page,
   input  logic [pba_pkg::COUNT_W-1:0]   req_page_count,
   input  logic                          req_region_usable,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic [pba_pkg::PAGE_W-1:0]    rsp_page_index,
   output logic [pba_pkg::COUNT_W-1:0]   rsp_free_count,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [pba_pkg::COUNT_W-1:0]   csr_write_data
);

   import pba_pkg::*;

   localparam int W         = MAP_WORD_BITS;
   localparam int MAP_WORDS = MAX_PAGES / MAP_WORD_BITS;
   localparam int BW        = $clog2(MAP_WORD_BITS);
   localparam int AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
   localparam int LOG_PAGES = $clog2(MAX_PAGES);
   localparam int PCW       = LOG_PAGES + 2 > 18 ? LOG_PAGES + 2 : 18;
   localparam int CW        = BW + 1;
   localparam logic [AW-1:0]  LAST_WORD = AW'(MAP_WORDS - 1);
   localparam logic [PCW-1:0] MAX_LIM   = PCW'(MAX_PAGES);

   // trailing zero count, W when zero
   function automatic logic [CW-1:0] tz(input logic [W-1:0] v);
      logic [CW-1:0] n;
      n = CW'(W);
      for (int j = W - 1; j >= 0; j--) begin
         if (v[j]) n = CW'(j);
      end
      return n;
   endfunction

   // leading zero count, W when zero
   function automatic logic [CW-1:0] lz(input logic [W-1:0] v);
      logic [CW-1:0] n;
      n = CW'(W);
      for (int j = 0; j < W; j++) begin
         if (v[j]) n = CW'(W - 1 - j);
      end
      return n;
   endfunction

   function automatic logic [CW-1:0] popc(input logic [W-1:0] v);
      logic [CW-1:0] n;
      n = '0;
      for (int j = 0; j < W; j++) begin
         n = n + CW'(v[j]);
      end
      return n;
   endfunction

   state_type        state_ff, state_in;
   cmd_type          op_ff, op_in;
   logic             wrap_ff, wrap_in;
   logic             mark_ff, mark_in;
   logic [PCW-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [PCW-1:0]   r_ff, r_in, count_ff, count_in, lim_ff, lim_in;
   logic [AW-1:0]    addr_ff, addr_in, clr_ff, clr_in;
   logic [PAGE_W-1:0]  hint_ff, hint_in, idx_ff, idx_in;
   logic [COUNT_W-1:0] ft_ff, ft_in, pages_ff, pages_in, floor_ff, floor_in;
   logic             st_ff, st_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0] rsp_free_ff, rsp_free_in;

   logic             wr_en, rd_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [W-1:0]     wr_data, old;

   pba_ram #(.WIDTH(W), .DEPTH(MAP_WORDS)) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (old)
   );

   // page range mask of the word in hand
   logic [PCW-1:0] wbase, pg;
   logic [W-1:0]   wmask;
   always_comb begin
      wbase = PCW'(addr_ff) << BW;
      pg    = '0;
      for (int j = 0; j < W; j++) begin
         pg       = wbase + PCW'(j);
         wmask[j] = (pg >= lo_ff) && (pg < hi_ff);
      end
   end

   // run search within the word, with the free run carried in
   logic [W-1:0]   eff, lowm, hit_b;
   logic [CW-1:0]  f0, hit_tz;
   logic [PCW-1:0] need, end_pg, start_pg;
   logic           a_ok, b_any, count_le_w, run_hit;
   logic [BW-1:0]  k_hit;
   always_comb begin
      eff        = old | ~wmask;
      f0         = tz(eff);
      need       = count_ff - r_ff;
      a_ok       = need <= PCW'(f0);
      count_le_w = count_ff <= PCW'(W);
      lowm       = {W{1'b1}} >> (CW'(W) - count_ff[CW-1:0]);
      for (int k = 0; k < W; k++) begin
         hit_b[k] = 1'b0;
         if (count_le_w && (PCW'(k) + 1'b1 >= count_ff)) begin
            hit_b[k] = (eff & (lowm << (PCW'(k) + 1'b1 - count_ff))) == '0;
         end
      end
      hit_tz   = tz(hit_b);
      b_any    = hit_b != '0;
      run_hit  = a_ok || b_any;
      k_hit    = a_ok ? (need[BW-1:0] - 1'b1) : hit_tz[BW-1:0];
      end_pg   = wbase + PCW'(k_hit);
      start_pg = end_pg + 1'b1 - count_ff;
   end

   // release and single-page helpers
   logic [W-1:0]       rel, fr;
   logic [CW-1:0]      rel_n, rel_tz, fr_tz;
   logic [PCW-1:0]     rel_pg, one_pg;
   logic [COUNT_W:0]   ft_sum;
   always_comb begin
      rel    = old & wmask;
      rel_n  = popc(rel);
      rel_tz = tz(rel);
      rel_pg = wbase + PCW'(rel_tz);
      ft_sum = {1'b0, ft_ff} + (COUNT_W + 1)'(rel_n);
      fr     = ~old & wmask;
      fr_tz  = tz(fr);
      one_pg = wbase + PCW'(fr_tz);
   end

   // sequencer: next state, map access and result
   logic            pass_end, more;
   logic [PCW-1:0]  req_end, req_base;
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      wrap_in       = wrap_ff;
      mark_in       = mark_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      r_in          = r_ff;
      count_in      = count_ff;
      lim_in        = lim_ff;
      addr_in       = addr_ff;
      clr_in        = clr_ff;
      hint_in       = hint_ff;
      idx_in        = idx_ff;
      ft_in         = ft_ff;
      st_in         = st_ff;
      pages_in      = pages_ff;
      floor_in      = floor_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_free_in   = rsp_free_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = old;
      rd_en         = 1'b0;
      rd_addr       = addr_ff + 1'b1;
      pass_end      = 1'b0;
      more          = addr_ff != AW'((hi_ff - 1'b1) >> BW);
      req_base      = PCW'(req_base_page);
      req_end       = req_base + PCW'(req_page_count);

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_WORD) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = cmd_type'(req_cmd);
               wrap_in  = 1'b0;
               mark_in  = 1'b0;
               st_in    = 1'b0;
               idx_in   = '0;
               r_in     = '0;
               count_in = PCW'(req_page_count);
               lim_in   = PCW'(pages_ff) > MAX_LIM ? MAX_LIM : PCW'(pages_ff);
               state_in = ST_SETUP;
               case (cmd_type'(req_cmd))
                  CMD_ADD: begin
                     lo_in = req_base > PCW'(floor_ff) ? req_base : PCW'(floor_ff);
                     hi_in = req_end < lim_in ? req_end : lim_in;
                     if (!req_region_usable) hi_in = '0;
                  end
                  CMD_ONE: begin
                     lo_in = PCW'(hint_ff);
                     hi_in = lim_in;
                  end
                  CMD_RUN: begin
                     lo_in = '0;
                     hi_in = req_page_count == '0 ? '0 : lim_in;
                  end
                  CMD_FREE: begin
                     lo_in = req_base;
                     hi_in = req_end < lim_in ? req_end : lim_in;
                  end
                  default: begin
                     hi_in = '0;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = lo_ff[BW +: AW];
               addr_in  = lo_ff[BW +: AW];
               state_in = ST_PROC;
            end else begin
               pass_end = 1'b1;
            end
         end
         ST_PROC: begin
            if (mark_ff) begin
               wr_en    = 1'b1;
               wr_data  = old | wmask;
               pass_end = !more;
            end else begin
               case (op_ff)
                  CMD_ADD, CMD_FREE: begin
                     wr_en    = 1'b1;
                     wr_data  = old & ~wmask;
                     ft_in    = ft_sum > (COUNT_W + 1)'(FREE_MAX) ? FREE_MAX
                                                                  : ft_sum[COUNT_W-1:0];
                     if (op_ff == CMD_FREE && rel != '0 && rel_pg < PCW'(hint_ff)) begin
                        hint_in = rel_pg[PAGE_W-1:0];
                     end
                     pass_end = !more;
                  end
                  CMD_ONE: begin
                     if (fr != '0) begin
                        wr_en    = 1'b1;
                        wr_data  = old | (W'(1) << fr_tz[BW-1:0]);
                        ft_in    = ft_ff == '0 ? '0 : ft_ff - 1'b1;
                        hint_in  = one_pg[PAGE_W-1:0];
                        idx_in   = one_pg[PAGE_W-1:0];
                        state_in = ST_FIN;
                     end else begin
                        pass_end = !more;
                     end
                  end
                  CMD_RUN: begin
                     if (run_hit) begin
                        lo_in    = start_pg;
                        hi_in    = end_pg + 1'b1;
                        mark_in  = 1'b1;
                        idx_in   = start_pg[PAGE_W-1:0];
                        ft_in    = PCW'(ft_ff) > count_ff ? COUNT_W'(PCW'(ft_ff) - count_ff)
                                                          : '0;
                        state_in = ST_SETUP;
                     end else begin
                        r_in     = eff == '0 ? r_ff + PCW'(W) : PCW'(lz(eff));
                        pass_end = !more;
                     end
                  end
                  default: begin
                     pass_end = 1'b1;
                  end
               endcase
            end
            // walk on to the next word
            if (state_in == ST_PROC && !pass_end) begin
               rd_en   = 1'b1;
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_index_in  = st_ff ? '0 : idx_ff;
               rsp_free_in   = ft_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // end of a pass over the range
      if (pass_end) begin
         state_in = ST_FIN;
         if (!mark_ff && op_ff == CMD_ONE && !wrap_ff) begin
            wrap_in  = 1'b1;
            lo_in    = '0;
            hi_in    = PCW'(hint_ff) < lim_ff ? PCW'(hint_ff) : lim_ff;
            state_in = ST_SETUP;
         end else if (!mark_ff && (op_ff == CMD_ONE || op_ff == CMD_RUN)) begin
            st_in = 1'b1;
         end
      end

      // register writes
      if (csr_write_enable) begin
         case (reg_type'(csr_index))
            REG_PAGES: pages_in = csr_write_data;
            REG_FLOOR: floor_in = csr_write_data;
            default:   pages_in = pages_ff;
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hint_ff      <= '0;
         ft_ff        <= '0;
         pages_ff     <= PAGES_RESET;
         floor_ff     <= FLOOR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hint_ff      <= hint_in;
         ft_ff        <= ft_in;
         pages_ff     <= pages_in;
         floor_ff     <= floor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      wrap_ff       <= wrap_in;
      mark_ff       <= mark_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      r_ff          <= r_in;
      count_ff      <= count_in;
      lim_ff        <= lim_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req_stall      = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_page_index = rsp_index_ff;
   assign rsp_free_count = rsp_free_ff;

endmodule

// File: design/pba_checker.sv
`include "page_bitmap_allocator_defines.svh"

module pba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_status,
   input logic [pba_pkg::PAGE_W-1:0]    rsp_page_index,
   input logic [pba_pkg::COUNT_W-1:0]   rsp_free_count
);

   // one item at a time: the input closes right after a take
   `PBA_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)

   // a failed allocation reports page zero
   `PBA_ASSERT_IMP(a_fail_index_zero, clock, reset, rsp_valid && rsp_status, rsp_page_index == '0)

   // a held result stays put
   `PBA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_page_index) && $stable(rsp_free_count))

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (.*);
